>>> design/csvt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csvt_pkg: shared definitions for the CSV byte stream tokenizer
// Character codes, input operation codes and token kinds.
// ----------------------------------------------------------------------------
package csvt_pkg;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_END  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_FIELD = 2'd1,
    KIND_ROW   = 2'd2
  } token_kind_e;

endpackage
`default_nettype wire

>>> design/csvt_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csvt_if: valid/ready channels of the CSV tokenizer
// Input channel carries op and a text byte, output channel carries a token.
// ----------------------------------------------------------------------------
interface csvt_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] text_byte;

  modport source (output valid, output op, output text_byte, input ready);
  modport sink   (input valid, input op, input text_byte, output ready);
endinterface

interface csvt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] token_kind;
  logic [7:0] content_byte;

  modport source (output valid, output token_kind, output content_byte, input ready);
  modport sink   (input valid, input token_kind, input content_byte, output ready);
endinterface
`default_nettype wire

>>> design/csv_byte_stream_tokenizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csv_byte_stream_tokenizer: CSV text to field/row token stream
// Reads CSV text one byte per transfer and emits content bytes, end-of-field
// and end-of-row tokens. Quoted fields keep commas, CR and LF; a doubled
// quote becomes one quote byte.
//
// Usage:
//   in_i  : op (0 = text byte, 1 = end of text) and text_byte.
//   out_o : token_kind (0 byte, 1 end of field, 2 end of field and row) and
//           content_byte (zero for marks).
//   Each input transfer yields zero or one output transfer, in order.
//   From input transfer to output valid an item passes one input register,
//   then the decode and flag update into the output register.
//   Throughput is one byte per cycle while out_o does not stall; the flag
//   update is the only loop.
//   Reset clears all parser flags and the valid bits of both pipeline registers.
//   When out_o stalls, the output register holds its token and one more item
//   waits in the input register; in_i.ready then drops until out_o moves.
//   An end-of-text item flushes a begun row and clears all parser flags.
// ----------------------------------------------------------------------------
module csv_byte_stream_tokenizer (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  csvt_in_if.sink   in_i,
  csvt_out_if.source out_o
);
  import csvt_pkg::*;

  typedef struct packed {
    logic inside_quotes;
    logic quote_pending;
    logic field_begun;
    logic field_has_bytes;
    logic row_has_fields;
  } flags_t;

  // input register
  logic       s1_valid_q;
  logic       s1_op_q;
  logic [7:0] s1_byte_q;
  logic       s1_adv;

  // parser state
  flags_t st_q, st_d;

  // result register
  logic        out_valid_q;
  token_kind_e out_kind_q;
  logic [7:0]  out_byte_q;

  logic        emit;
  token_kind_e kind;
  logic [7:0]  tok_byte;
  logic        outside;
  logic        row_begun;

  assign s1_adv     = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || s1_adv;

  assign row_begun = st_q.row_has_fields || st_q.field_begun || st_q.field_has_bytes;

  always_comb begin
    st_d     = st_q;
    emit     = 1'b0;
    kind     = KIND_BYTE;
    tok_byte = 8'h00;
    outside  = 1'b0;
    if (op_e'(s1_op_q) == OP_END) begin
      if (row_begun) begin
        emit = 1'b1;
        kind = KIND_ROW;
      end
      st_d = '0;
    end else begin
      if (st_q.quote_pending) begin
        st_d.quote_pending = 1'b0;
        if (s1_byte_q == CH_QUOTE) begin
          emit                 = 1'b1;
          tok_byte             = CH_QUOTE;
          st_d.field_begun     = 1'b1;
          st_d.field_has_bytes = 1'b1;
        end else begin
          // closing quote: the byte is then handled as an unquoted one
          st_d.inside_quotes = 1'b0;
          outside            = 1'b1;
        end
      end else if (st_q.inside_quotes) begin
        if (s1_byte_q == CH_QUOTE) begin
          st_d.quote_pending = 1'b1;
        end else begin
          emit                 = 1'b1;
          tok_byte             = s1_byte_q;
          st_d.field_begun     = 1'b1;
          st_d.field_has_bytes = 1'b1;
        end
      end else begin
        outside = 1'b1;
      end

      if (outside) begin
        unique case (s1_byte_q)
          CH_QUOTE: begin
            st_d.inside_quotes = 1'b1;
            st_d.field_begun   = 1'b1;
          end
          CH_COMMA: begin
            emit                 = 1'b1;
            kind                 = KIND_FIELD;
            st_d.row_has_fields  = 1'b1;
            st_d.field_has_bytes = 1'b0;
            st_d.field_begun     = 1'b1;
          end
          CH_CR: begin
          end
          CH_LF: begin
            // blank line gives no row mark
            if (row_begun) begin
              emit                 = 1'b1;
              kind                 = KIND_ROW;
              st_d.row_has_fields  = 1'b0;
              st_d.field_begun     = 1'b0;
              st_d.field_has_bytes = 1'b0;
            end
          end
          default: begin
            emit                 = 1'b1;
            tok_byte             = s1_byte_q;
            st_d.field_begun     = 1'b1;
            st_d.field_has_bytes = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_op_q   <= in_i.op;
      s1_byte_q <= in_i.text_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (s1_valid_q && s1_adv) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q && emit) begin
      out_kind_q <= kind;
      out_byte_q <= tok_byte;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.token_kind   = out_kind_q;
  assign out_o.content_byte = out_byte_q;

endmodule
`default_nettype wire

>>> design/csvt_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csvt_checker: port-level checks for the CSV tokenizer
// Watches both channels of the top level; attached by bind.
// ----------------------------------------------------------------------------
module csvt_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [1:0] token_kind_i,
  input wire logic [7:0] content_byte_i
);
  import csvt_pkg::*;

  // a stalled token holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(token_kind_i)
      && $stable(content_byte_i))
    else $error("output token changed while stalled");

  a_kind_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (token_kind_i == KIND_BYTE || token_kind_i == KIND_FIELD
      || token_kind_i == KIND_ROW))
    else $error("unknown token kind");

  a_mark_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && token_kind_i != KIND_BYTE |-> content_byte_i == 8'h00)
    else $error("field or row mark carries a nonzero byte");

  // a fresh token always follows an input transfer through the input register
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("token appeared without a matching input transfer");

  // with the output register empty nothing holds back the input
  a_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with an empty output register");

endmodule

bind csv_byte_stream_tokenizer csvt_checker u_csvt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .token_kind_i   (out_o.token_kind),
  .content_byte_i (out_o.content_byte)
);
`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for csv_byte_stream_tokenizer
// Feeds directed corner cases and then random CSV text (well-formed rows with
// quoted and plain fields, mixed with raw noise and end-of-text items) into
// the input channel. A scoreboard predicts every token and checks each output
// transfer in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import csvt_pkg::*;

  localparam int RANDOM_ITEMS = 1300;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    op_e        op;
    logic [7:0] ch;
  } text_item_t;

  typedef struct packed {
    token_kind_e kind;
    logic [7:0]  ch;
  } token_t;

  logic clk_i;
  logic rst_ni;

  csvt_in_if  in_if ();
  csvt_out_if out_if ();

  csv_byte_stream_tokenizer DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  text_item_t text_q[$];
  token_t     token_q[$];

  // predictor flags
  logic quote_open, quote_wait, field_open, field_has_data, row_has_field;

  int cycle_cnt;
  int err_cnt;
  int sent_bytes, sent_ends;
  int got_bytes, got_fields, got_rows;
  int send_gap, stall_left;
  text_item_t next_item;
  token_t     seen;
  token_t     want;

  // both sides run without idling through one quarter of the time, in repeating windows
  function automatic logic calm();
    return (cycle_cnt / 128) % 4 == 3;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic is_special(input logic [7:0] ch);
    return ch == CH_QUOTE || ch == CH_COMMA || ch == CH_CR || ch == CH_LF;
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] ch;
    do ch = 8'($urandom_range(0, 255)); while (is_special(ch));
    return ch;
  endfunction

  function automatic logic [7:0] any_char();
    if ($urandom_range(0, 9) < 3) begin
      case ($urandom_range(0, 3))
        0: return CH_QUOTE;
        1: return CH_COMMA;
        2: return CH_CR;
        default: return CH_LF;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic push_text(input logic [7:0] ch);
    text_q.insert(text_q.size(), text_item_t'{OP_BYTE, ch});
  endtask

  task automatic push_end();
    text_q.insert(text_q.size(), text_item_t'{OP_END, 8'($urandom_range(0, 255))});
  endtask

  task automatic add_token(input token_kind_e kind, input logic [7:0] ch);
    token_q.insert(token_q.size(), token_t'{kind, ch});
  endtask

  // ---------------------------------------------------------------- predictor
  function automatic logic row_open();
    return row_has_field || field_open || field_has_data;
  endfunction

  task automatic scan_outside(input logic [7:0] ch);
    case (ch)
      CH_QUOTE: begin
        quote_open = 1'b1;
        field_open = 1'b1;
      end
      CH_COMMA: begin
        row_has_field  = 1'b1;
        field_has_data = 1'b0;
        field_open     = 1'b1;
        add_token(KIND_FIELD, 8'h00);
      end
      CH_CR: begin
      end
      CH_LF: begin
        if (row_open()) begin
          row_has_field  = 1'b0;
          field_open     = 1'b0;
          field_has_data = 1'b0;
          add_token(KIND_ROW, 8'h00);
        end
      end
      default: begin
        field_open     = 1'b1;
        field_has_data = 1'b1;
        add_token(KIND_BYTE, ch);
      end
    endcase
  endtask

  task automatic predict_tokens(input op_e op, input logic [7:0] ch);
    if (op == OP_END) begin
      if (row_open()) add_token(KIND_ROW, 8'h00);
      {quote_open, quote_wait, field_open, field_has_data, row_has_field} = '0;
    end else if (quote_wait) begin
      quote_wait = 1'b0;
      if (ch == CH_QUOTE) begin
        field_open     = 1'b1;
        field_has_data = 1'b1;
        add_token(KIND_BYTE, CH_QUOTE);
      end else begin
        quote_open = 1'b0;
        scan_outside(ch);
      end
    end else if (quote_open) begin
      if (ch == CH_QUOTE) begin
        quote_wait = 1'b1;
      end else begin
        field_open     = 1'b1;
        field_has_data = 1'b1;
        add_token(KIND_BYTE, ch);
      end
    end else begin
      scan_outside(ch);
    end
  endtask

  // ------------------------------------------------------------ clock, reset
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    in_if.valid     = 1'b0;
    in_if.op        = OP_BYTE;
    in_if.text_byte = 8'h00;
    out_if.ready    = 1'b0;
    {quote_open, quote_wait, field_open, field_has_data, row_has_field} = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d tokens outstanding", cycle_cnt, token_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ------------------------------------------------------------------ driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_tokens(op_e'(in_if.op), in_if.text_byte);
        if (in_if.op == OP_END) sent_ends++;
        else sent_bytes++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (send_gap > 0 && !calm()) begin
          send_gap--;
          in_if.valid <= 1'b0;
        end else if (text_q.size() > 0) begin
          next_item = text_q.pop_front();
          in_if.valid     <= 1'b1;
          in_if.op        <= next_item.op;
          in_if.text_byte <= next_item.ch;
          send_gap = pick_gap();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ----------------------------------------------------------------- monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        seen = token_t'{token_kind_e'(out_if.token_kind), out_if.content_byte};
        case (seen.kind)
          KIND_BYTE:  got_bytes++;
          KIND_FIELD: got_fields++;
          default:    got_rows++;
        endcase
        if (token_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: unexpected token kind=%0d byte=%02h", $realtime,
                     seen.kind, seen.ch);
        end else begin
          want = token_q.pop_front();
          if (seen.kind !== want.kind || seen.ch !== want.ch) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("%0t: token mismatch: expected kind=%0d byte=%02h, got kind=%0d byte=%02h",
                       $realtime, want.kind, want.ch, seen.kind, seen.ch);
          end
        end
      end
      if (stall_left > 0 && !calm()) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // --------------------------------------------------------------- stimulus
  initial begin
    int sel, nf, len;
    logic [7:0] ch;

    cycle_cnt  = 0;
    err_cnt    = 0;
    sent_bytes = 0;
    sent_ends  = 0;
    got_bytes  = 0;
    got_fields = 0;
    got_rows   = 0;

    // blank line, dropped CR, extreme byte values, field end
    push_text(CH_LF); push_text(CH_CR); push_text(8'h00); push_text(8'hFF);
    push_text(CH_COMMA);
    // quoted section holding comma, CR and LF; doubled quote; closing quote
    push_text(CH_QUOTE); push_text(CH_COMMA); push_text(CH_CR); push_text(CH_LF);
    push_text(CH_QUOTE); push_text(CH_QUOTE); push_text(CH_QUOTE); push_text("a");
    // quote opening mid-field, closed only by end of text
    push_text(CH_QUOTE); push_end();
    // end of text with nothing begun
    push_end();
    // end of text with a quote still pending
    push_text(CH_QUOTE); push_text(CH_QUOTE); push_end();
    // empty fields, CR before a blank line, lone byte flushed at end
    push_text(CH_COMMA); push_text(CH_LF); push_text(CH_CR); push_text(CH_LF);
    push_text("x"); push_end();

    while (text_q.size() < 25 + RANDOM_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 80) begin
        nf = $urandom_range(1, 4);
        for (int f = 0; f < nf; f++) begin
          if (f > 0) push_text(CH_COMMA);
          len = $urandom_range(0, 5);
          if ($urandom_range(0, 2) == 0) begin
            push_text(CH_QUOTE);
            for (int k = 0; k < len; k++) begin
              ch = any_char();
              push_text(ch);
              if (ch == CH_QUOTE) push_text(CH_QUOTE);
            end
            push_text(CH_QUOTE);
          end else begin
            for (int k = 0; k < len; k++) push_text(plain_char());
          end
        end
        case ($urandom_range(0, 9))
          0:       push_end();
          1, 2, 3: begin push_text(CH_CR); push_text(CH_LF); end
          default: push_text(CH_LF);
        endcase
      end else if (sel < 92) begin
        // raw noise, may break quoting
        repeat ($urandom_range(1, 6)) push_text(any_char());
      end else if (sel < 96) begin
        push_end();
      end else begin
        if ($urandom_range(0, 1) == 0) push_text(CH_CR);
        push_text(CH_LF);
      end
    end

    @(posedge rst_ni);
    while (text_q.size() > 0 || in_if.valid) @(posedge clk_i);
    while (token_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (token_q.size() > 0) begin
      err_cnt++;
      $display("%0d expected tokens never arrived", token_q.size());
    end
    $display("Sent %0d text bytes and %0d end-of-text items in %0d cycles",
             sent_bytes, sent_ends, cycle_cnt);
    $display("Checked %0d content bytes, %0d field ends, %0d row ends; %0d errors",
             got_bytes, got_fields, got_rows, err_cnt);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> sim.f
design/csvt_pkg.sv
design/csvt_if.sv
design/csv_byte_stream_tokenizer.sv
design/csvt_checker.sv
verif/tb_top.sv
